@@ rtl/unsharp_mask_separable_gaussian_defines.svh @@
// assertion macros shared by the unsharp mask design
`ifndef UNSHARP_MASK_SEPARABLE_GAUSSIAN_DEFINES_SVH
`define UNSHARP_MASK_SEPARABLE_GAUSSIAN_DEFINES_SVH
`ifndef SYNTHESIS
`define USM_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("usm check failed");
`define USM_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("usm check failed");
`else
`define USM_ASSERT_IMP(name, pre, post)
`define USM_ASSERT_NXT(name, pre, post)
`endif
`endif

@@ rtl/usm_pkg.sv @@
// shared types and constants of the unsharp mask design
package usm_pkg;
	localparam int PIX_W      = 8;
	localparam int SIZE_W     = 11;
	localparam int THR_W      = 8;
	localparam int GAIN_W     = 12;
	localparam int TAP_W      = 16;
	localparam int OUT_W      = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int ROW_W      = 12;
	localparam int MAX_TAPS   = 4;
	localparam int PAIR_W     = 9;
	localparam int VPROD_W    = 25;
	localparam int VSUM_W     = 27;
	localparam int HPAIR_W    = 28;
	localparam int HPROD_W    = 44;
	localparam int SMOOTH_W   = 46;
	localparam int DET_W      = 48;
	localparam int HALF_W     = 24;

	typedef logic [MAX_TAPS-1:0][TAP_W-1:0] tap_vec_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 4'd0,
		CFG_FRAME_HEIGHT = 4'd1,
		CFG_CORE_THR     = 4'd2,
		CFG_GAIN         = 4'd3,
		CFG_TAP_CENTER   = 4'd4,
		CFG_TAP_ONE      = 4'd5,
		CFG_TAP_TWO      = 4'd6,
		CFG_TAP_THREE    = 4'd7
	} cfg_reg_e;

	localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;
	localparam logic [GAIN_W-1:0] GAIN_RST = 12'd256;
	localparam tap_vec_t TAP_RST = {16'd0, 16'd0, 16'd0, 16'hFFFF};

	typedef struct packed {
		logic valid;
		logic last;
	} usm_tag_t;
endpackage

@@ rtl/usm_if.sv @@
// stream and configuration channel interfaces
interface usm_pix_if;
	import usm_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             flush;
	modport source(output valid, output pixel_value, output flush, input ready);
	modport sink(input valid, input pixel_value, input flush, output ready);
endinterface

interface usm_res_if;
	import usm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] sharpened;
	logic                    frame_end;
	modport source(output valid, output sharpened, output frame_end, input ready);
	modport sink(input valid, input sharpened, input frame_end, output ready);
endinterface

interface usm_cfg_if;
	import usm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/usm_col_cell.sv @@
// window column cell: holds one pixel column and forms its symmetric row pairs
module usm_col_cell #(
	parameter int RADIUS = 3
) (
	input  logic                                        clk,
	input  logic                                        shift,
	input  logic                                        mask,
	input  logic [2*RADIUS:0][usm_pkg::PIX_W-1:0]       col_in,
	output logic [2*RADIUS:0][usm_pkg::PIX_W-1:0]       col_q,
	output logic [RADIUS:0][usm_pkg::PAIR_W-1:0]        pair_s2
);
	import usm_pkg::*;

	logic [RADIUS:0][PAIR_W-1:0] pair_c;

	always_comb begin
		pair_c[0] = PAIR_W'(col_in[RADIUS]);
		for (int d = 1; d <= RADIUS; d++) begin
			pair_c[d] = PAIR_W'(col_in[RADIUS-d]) + PAIR_W'(col_in[RADIUS+d]);
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q   <= col_in;
			pair_s2 <= mask ? pair_c : '0;
		end
	end
endmodule

@@ rtl/usm_line_buf.sv @@
// column history memory with read-after-write forwarding
module usm_line_buf #(
	parameter int DEPTH = 1024,
	parameter int ROWS  = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   rd_en,
	input  logic [$clog2(DEPTH)-1:0]               rd_addr,
	input  logic                                   wr_en,
	input  logic [$clog2(DEPTH)-1:0]               wr_addr,
	input  logic [ROWS-1:0][usm_pkg::PIX_W-1:0]    wr_data,
	output logic [ROWS-1:0][usm_pkg::PIX_W-1:0]    hist
);
	import usm_pkg::*;

	logic [ROWS-1:0][PIX_W-1:0] mem [DEPTH];
	logic [ROWS-1:0][PIX_W-1:0] rd_q;
	logic [ROWS-1:0][PIX_W-1:0] fwd_data_q;
	logic                       fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign hist = fwd_q ? fwd_data_q : rd_q;
endmodule

@@ rtl/usm_filter.sv @@
// smoothing, coring, gain, rounding and saturation pipeline with output register
module usm_filter #(
	parameter int RADIUS = 3
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  en,
	input  usm_pkg::usm_tag_t                                     tag_s2,
	input  logic [usm_pkg::PIX_W-1:0]                             p_s2,
	input  logic [2*RADIUS:0][RADIUS:0][usm_pkg::PAIR_W-1:0]      pairs_s2,
	input  usm_pkg::tap_vec_t                                     taps,
	input  logic [usm_pkg::THR_W-1:0]                             thr,
	input  logic [usm_pkg::GAIN_W-1:0]                            gain,
	output logic                                                  res_valid,
	output logic signed [usm_pkg::OUT_W-1:0]                      res_sharp,
	output logic                                                  res_last
);
	import usm_pkg::*;

	localparam int SIDE = 2*RADIUS+1;

	usm_tag_t tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [PIX_W-1:0] p_s3, p_s4, p_s5, p_s6, p_s7, p_s8;

	logic [SIDE-1:0][RADIUS:0][VPROD_W-1:0] vprod_s3;
	logic [SIDE-1:0][VSUM_W-1:0]            vsum_c, vsum_s4;
	logic [RADIUS:0][HPROD_W-1:0]           hprod_c, hprod_s5;
	logic [SMOOTH_W-1:0]                    smooth_c, smooth_s6;
	logic signed [DET_W-1:0]                det_c, thrs_c, cored_c, cored_s7;
	logic signed [HALF_W+GAIN_W:0]          phi_s8;
	logic [HALF_W+GAIN_W-1:0]               plo_s8;
	logic signed [63:0]                     acc_c, q_c;
	logic signed [OUT_W-1:0]                sat_c;

	always_comb begin
		for (int k = 0; k < SIDE; k++) begin
			vsum_c[k] = '0;
			for (int d = 0; d <= RADIUS; d++) begin
				vsum_c[k] = vsum_c[k] + VSUM_W'(vprod_s3[k][d]);
			end
		end
	end

	always_comb begin
		hprod_c[0] = HPROD_W'(vsum_s4[RADIUS]) * HPROD_W'(taps[0]);
		for (int d = 1; d <= RADIUS; d++) begin
			hprod_c[d] = HPROD_W'(HPAIR_W'(vsum_s4[RADIUS-d]) + HPAIR_W'(vsum_s4[RADIUS+d]))
				* HPROD_W'(taps[d]);
		end
	end

	always_comb begin
		smooth_c = '0;
		for (int d = 0; d <= RADIUS; d++) begin
			smooth_c = smooth_c + SMOOTH_W'(hprod_s5[d]);
		end
	end

	always_comb begin
		det_c  = $signed({8'd0, p_s6, 32'd0}) - $signed({2'd0, smooth_s6});
		thrs_c = $signed({8'd0, thr, 32'd0});
		if (det_c >= thrs_c) begin
			cored_c = det_c - thrs_c;
		end else if (det_c <= -thrs_c) begin
			cored_c = det_c + thrs_c;
		end else begin
			cored_c = '0;
		end
	end

	always_comb begin
		acc_c = $signed({16'd0, p_s8, 40'd0}) + (64'(phi_s8) <<< HALF_W)
			+ $signed(64'(plo_s8)) + 64'sh80_0000_0000;
		q_c = acc_c >>> 40;
		if (q_c > 64'sd2047) begin
			sat_c = 12'sd2047;
		end else if (q_c < -64'sd2048) begin
			sat_c = -12'sd2048;
		end else begin
			sat_c = q_c[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3    <= '0;
			tag_s4    <= '0;
			tag_s5    <= '0;
			tag_s6    <= '0;
			tag_s7    <= '0;
			tag_s8    <= '0;
			res_valid <= 1'b0;
		end else if (en) begin
			tag_s3    <= tag_s2;
			tag_s4    <= tag_s3;
			tag_s5    <= tag_s4;
			tag_s6    <= tag_s5;
			tag_s7    <= tag_s6;
			tag_s8    <= tag_s7;
			res_valid <= tag_s8.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SIDE; k++) begin
				for (int d = 0; d <= RADIUS; d++) begin
					vprod_s3[k][d] <= VPROD_W'(pairs_s2[k][d]) * VPROD_W'(taps[d]);
				end
			end
			p_s3      <= p_s2;
			vsum_s4   <= vsum_c;
			p_s4      <= p_s3;
			hprod_s5  <= hprod_c;
			p_s5      <= p_s4;
			smooth_s6 <= smooth_c;
			p_s6      <= p_s5;
			cored_s7  <= cored_c;
			p_s7      <= p_s6;
			plo_s8    <= (HALF_W+GAIN_W)'(cored_s7[HALF_W-1:0]) * (HALF_W+GAIN_W)'(gain);
			phi_s8    <= $signed(cored_s7[DET_W-1:HALF_W]) * $signed({1'b0, gain});
			p_s8      <= p_s7;
			res_sharp <= sat_c;
			res_last  <= tag_s8.last;
		end
	end
endmodule

@@ rtl/unsharp_mask_separable_gaussian.sv @@
// Unsharp mask with coring over a raster pixel stream. One pixel word is taken per clock and
// results leave one per clock once the pipeline is full, as long as no finished result waits;
// each result follows its input by MAX_RADIUS rows plus MAX_RADIUS pixels of the frame's item
// sequence, so after each frame the host sends MAX_RADIUS*width+MAX_RADIUS flush words, and the
// last of them yields frame_end. Inside, a word passes a position stage with the line memory
// read (one read and one write port, column history of 2*MAX_RADIUS rows), a row of
// 2*MAX_RADIUS+1 column cells that form the window, and seven arithmetic stages ending in the
// output register. The whole pipe halts while a finished result waits. The line memory needs
// no clearing: rows from earlier frames and columns outside the frame are masked to zero.
`include "unsharp_mask_separable_gaussian_defines.svh"
module unsharp_mask_separable_gaussian #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic  clk,
	input  logic  arst_n,
	usm_pix_if.sink   pix,
	usm_res_if.source res,
	usm_cfg_if.sink   cfg
);
	import usm_pkg::*;

	localparam int SIDE = 2*MAX_RADIUS+1;
	localparam int HROWS = 2*MAX_RADIUS;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH+1);
	localparam int LW = $clog2(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1);

	// configuration registers
	logic [SIZE_W-1:0] width_q, height_q;
	logic [THR_W-1:0]  thr_q;
	logic [GAIN_W-1:0] gain_q;
	tap_vec_t          taps_q;

	// frame position state
	logic              start_q, act_q;
	logic [WW-1:0]     cur_w_q;
	logic [SIZE_W-1:0] cur_h_q, or_q;
	logic [LW-1:0]     lag_q, n_q;
	logic [CW-1:0]     c_q, oc_q;
	logic [ROW_W-1:0]  r_q;

	logic              en, acc, produce, last, c_wrap, o_last_col, o_last_row, act_e;
	logic [WW-1:0]     w_new, w_e;
	logic [SIZE_W-1:0] h_new, h_e, or_e;
	logic [LW-1:0]     lag_new, lag_e, n_e;
	logic [CW-1:0]     c_e, oc_e;
	logic [ROW_W-1:0]  r_e;
	logic [PIX_W-1:0]  pix_e;
	logic [SIDE-1:0]   rmask_c, cmask_c;

	// stage 1
	logic              v_s1, prod_s1, last_s1;
	logic [CW-1:0]     addr_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [SIDE-1:0]   rmask_s1, cmask_s1;

	logic [HROWS-1:0][PIX_W-1:0] hist, wr_data;
	logic [SIDE-1:0][PIX_W-1:0]  col_new;
	logic [SIDE-1:0][PIX_W-1:0]  win_q  [SIDE];
	logic [SIDE-1:0][PIX_W-1:0]  win_in [SIDE];
	logic [SIDE-1:0][MAX_RADIUS:0][PAIR_W-1:0] pairs_s2;
	logic [PIX_W-1:0]  p_s2;
	usm_tag_t          tag_s2;
	logic              shift;

	logic              f_valid, f_last;
	logic signed [OUT_W-1:0] f_sharp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RST;
			height_q <= SIZE_RST;
			thr_q    <= '0;
			gain_q   <= GAIN_RST;
			taps_q   <= TAP_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_FRAME_WIDTH:  width_q   <= cfg.data[SIZE_W-1:0];
				CFG_FRAME_HEIGHT: height_q  <= cfg.data[SIZE_W-1:0];
				CFG_CORE_THR:     thr_q     <= cfg.data[THR_W-1:0];
				CFG_GAIN:         gain_q    <= cfg.data[GAIN_W-1:0];
				CFG_TAP_CENTER:   taps_q[0] <= cfg.data;
				CFG_TAP_ONE:      taps_q[1] <= cfg.data;
				CFG_TAP_TWO:      taps_q[2] <= cfg.data;
				CFG_TAP_THREE:    taps_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign en  = !f_valid || res.ready;
	assign pix.ready = en;
	assign acc = pix.valid && en;

	always_comb begin
		if (width_q == '0) begin
			w_new = WW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(width_q);
		end
		h_new   = (height_q == '0) ? SIZE_W'(1) : height_q;
		lag_new = LW'(MAX_RADIUS * int'(w_new) + MAX_RADIUS);

		w_e   = start_q ? w_new : cur_w_q;
		h_e   = start_q ? h_new : cur_h_q;
		lag_e = start_q ? lag_new : lag_q;
		c_e   = start_q ? '0 : c_q;
		r_e   = start_q ? '0 : r_q;
		n_e   = start_q ? '0 : n_q;
		act_e = start_q ? 1'b0 : act_q;
		oc_e  = start_q ? '0 : oc_q;
		or_e  = start_q ? '0 : or_q;

		pix_e = (pix.flush || (r_e >= ROW_W'(h_e))) ? '0 : pix.pixel_value;
		produce    = act_e || (n_e == lag_e);
		c_wrap     = (WW'(c_e) + WW'(1)) == w_e;
		o_last_col = (WW'(oc_e) + WW'(1)) == w_e;
		o_last_row = (or_e + SIZE_W'(1)) == h_e;
		last       = produce && o_last_col && o_last_row;

		for (int k = 0; k < SIDE; k++) begin
			rmask_c[k] = (int'(r_e) + k >= HROWS) && (int'(r_e) + k < int'(h_e) + HROWS);
			cmask_c[k] = (int'(oc_e) + k >= MAX_RADIUS)
				&& (int'(oc_e) + k < int'(w_e) + MAX_RADIUS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			act_q   <= 1'b0;
			cur_w_q <= WW'(1);
			cur_h_q <= SIZE_W'(1);
			lag_q   <= '0;
			n_q     <= '0;
			c_q     <= '0;
			r_q     <= '0;
			oc_q    <= '0;
			or_q    <= '0;
		end else if (acc) begin
			start_q <= last;
			cur_w_q <= w_e;
			cur_h_q <= h_e;
			lag_q   <= lag_e;
			act_q   <= produce;
			n_q     <= produce ? n_e : n_e + LW'(1);
			if (c_wrap) begin
				c_q <= '0;
				r_q <= r_e + ROW_W'(1);
			end else begin
				c_q <= c_e + CW'(1);
				r_q <= r_e;
			end
			if (produce && o_last_col) begin
				oc_q <= '0;
				or_q <= or_e + SIZE_W'(1);
			end else if (produce) begin
				oc_q <= oc_e + CW'(1);
				or_q <= or_e;
			end else begin
				oc_q <= oc_e;
				or_q <= or_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			prod_s1  <= produce;
			last_s1  <= last;
			addr_s1  <= c_e;
			pix_s1   <= pix_e;
			rmask_s1 <= rmask_c;
			cmask_s1 <= cmask_c;
		end
	end

	usm_line_buf #(
		.DEPTH (MAX_WIDTH),
		.ROWS  (HROWS)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (c_e),
		.wr_en   (shift),
		.wr_addr (addr_s1),
		.wr_data (wr_data),
		.hist    (hist)
	);

	assign shift   = v_s1 && en;
	assign wr_data = {hist[HROWS-2:0], pix_s1};

	always_comb begin
		for (int k = 0; k < HROWS; k++) begin
			col_new[k] = rmask_s1[k] ? hist[HROWS-1-k] : '0;
		end
		col_new[HROWS] = rmask_s1[HROWS] ? pix_s1 : '0;
	end

	for (genvar k = 0; k < SIDE; k++) begin : g_cell
		if (k == SIDE-1) begin : g_head
			assign win_in[k] = col_new;
		end else begin : g_body
			assign win_in[k] = win_q[k+1];
		end
		usm_col_cell #(
			.RADIUS (MAX_RADIUS)
		) u_cell (
			.clk     (clk),
			.shift   (shift),
			.mask    (cmask_s1[k]),
			.col_in  (win_in[k]),
			.col_q   (win_q[k]),
			.pair_s2 (pairs_s2[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2.valid <= v_s1 && prod_s1;
			tag_s2.last  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			p_s2 <= win_in[MAX_RADIUS][MAX_RADIUS];
		end
	end

	usm_filter #(
		.RADIUS (MAX_RADIUS)
	) u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.tag_s2    (tag_s2),
		.p_s2      (p_s2),
		.pairs_s2  (pairs_s2),
		.taps      (taps_q),
		.thr       (thr_q),
		.gain      (gain_q),
		.res_valid (f_valid),
		.res_sharp (f_sharp),
		.res_last  (f_last)
	);

	assign res.valid     = f_valid;
	assign res.sharpened = f_sharp;
	assign res.frame_end = f_last;

	`USM_ASSERT_NXT(a_restart_after_last, acc && last, start_q)
	`USM_ASSERT_IMP(a_col_in_frame, !start_q, WW'(c_q) < cur_w_q)
	`USM_ASSERT_IMP(a_lag_count, !start_q && !act_q, n_q <= lag_q)
	`USM_ASSERT_NXT(a_s1_holds_on_stall, v_s1 && !en, v_s1)
endmodule
